>>> rtl/core/hzd_pkg.sv
// Shared types and codes for the HZ stream decoder.
package hzd_pkg;

	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [7:0] CH_ENTER   = 8'h7B;
	localparam logic [7:0] CH_LEAVE   = 8'h7D;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		KIND_ASCII = 2'd0,
		KIND_GB    = 2'd1,
		KIND_UNK1  = 2'd2,
		KIND_UNK2  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic       emit;
		kind_t      item_kind;
		logic [7:0] byte_high;
		logic [7:0] byte_low;
	} result_t;

endpackage

>>> rtl/core/hzd_in_stage.sv
// Input register stage of the HZ stream decoder.
module hzd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  hzd_pkg::in_item_t s_item,
	input  logic              advance,
	output logic              valid_s1,
	output hzd_pkg::in_item_t item_s1
);
	import hzd_pkg::*;

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= s_item;
		end
	end

endmodule

>>> rtl/core/hzd_decode.sv
// Decode state and next-item logic of the HZ stream decoder.
module hzd_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  hzd_pkg::in_item_t item_s1,
	output hzd_pkg::result_t  result
);
	import hzd_pkg::*;

	typedef enum logic [2:0] {
		MODE_PLAIN    = 3'd0,
		MODE_TILDE    = 3'd1,
		MODE_GB       = 3'd2,
		MODE_GB_TILDE = 3'd3,
		MODE_GB_HALF  = 3'd4,
		MODE_GR_HALF  = 3'd5
	} mode_t;

	mode_t      mode_q;
	mode_t      mode_d;
	logic [7:0] prev_q;
	logic [7:0] b;
	logic       gl;
	logic       gr;
	logic       pending;

	assign b  = item_s1.in_byte;
	assign gl = b[6:0] inside {[7'h21:7'h7E]};
	assign gr = b inside {[8'hA1:8'hFE]};

	always_comb begin
		result = '{emit: 1'b0, item_kind: KIND_ASCII, byte_high: 8'h00, byte_low: b};
		mode_d = mode_q;
		case (mode_q)
			MODE_TILDE: begin
				if (b == CH_ENTER) begin
					mode_d = MODE_GB;
				end else begin
					if (b == CH_TILDE) begin
						result.emit = 1'b1;
					end else if (b != CH_NEWLINE) begin
						result.emit      = 1'b1;
						result.item_kind = KIND_UNK2;
						result.byte_high = prev_q;
					end
					mode_d = MODE_PLAIN;
				end
			end
			MODE_GB_TILDE: begin
				if (b == CH_LEAVE || b == CH_NEWLINE) begin
					mode_d = MODE_PLAIN;
				end else begin
					result.emit      = 1'b1;
					result.item_kind = gl ? KIND_GB : KIND_UNK2;
					result.byte_high = prev_q;
					mode_d           = MODE_GB;
				end
			end
			MODE_GB: begin
				if (b == CH_TILDE) begin
					mode_d = MODE_GB_TILDE;
				end else if (gl) begin
					mode_d = MODE_GB_HALF;
				end else begin
					result.emit      = 1'b1;
					result.item_kind = KIND_UNK1;
				end
			end
			MODE_GB_HALF: begin
				result.emit      = 1'b1;
				result.item_kind = gl ? KIND_GB : KIND_UNK2;
				result.byte_high = prev_q;
				mode_d           = MODE_GB;
			end
			MODE_GR_HALF: begin
				result.emit      = 1'b1;
				result.item_kind = gr ? KIND_GB : KIND_UNK2;
				result.byte_high = prev_q;
				mode_d           = MODE_PLAIN;
			end
			default: begin
				mode_d = MODE_PLAIN;
				if (b == CH_TILDE) begin
					mode_d = MODE_TILDE;
				end else if (gr) begin
					mode_d = MODE_GR_HALF;
				end else begin
					result.emit      = 1'b1;
					result.item_kind = b[7] ? KIND_UNK1 : KIND_ASCII;
				end
			end
		endcase
		pending = (mode_d == MODE_TILDE) || (mode_d == MODE_GB_TILDE) ||
		          (mode_d == MODE_GB_HALF) || (mode_d == MODE_GR_HALF);
		if (item_s1.end_of_text && pending && !result.emit) begin
			result.emit      = 1'b1;
			result.item_kind = KIND_UNK1;
			result.byte_high = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			prev_q <= 8'h00;
		end else if (advance) begin
			if (item_s1.end_of_text) begin
				mode_q <= MODE_PLAIN;
				prev_q <= 8'h00;
			end else begin
				mode_q <= mode_d;
				prev_q <= b;
			end
		end
	end

	a_reset_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_text |=> mode_q == MODE_PLAIN && prev_q == 8'h00)
		else $error("state not cleared after last item");

	a_single_zero_high: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.emit &&
		(result.item_kind == KIND_ASCII || result.item_kind == KIND_UNK1)
		|-> result.byte_high == 8'h00)
		else $error("single-byte item with nonzero high byte");

	a_tilde_enters: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.end_of_text && mode_q == MODE_PLAIN && b == CH_TILDE
		|=> mode_q == MODE_TILDE && prev_q == CH_TILDE)
		else $error("tilde in plain mode did not enter tilde state");

endmodule

>>> rtl/core/hzd_out_stage.sv
// Result register stage of the HZ stream decoder.
module hzd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  hzd_pkg::result_t result,
	output logic             advance,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic [1:0]       m_tuser
);
	import hzd_pkg::*;

	result_t res_s2;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign m_tdata  = {res_s2.byte_low, res_s2.byte_high};
	assign m_tuser  = res_s2.item_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= result.emit;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.emit) begin
			res_s2 <= result;
		end
	end

endmodule

>>> rtl/core/hz_gb2312_stream_decoder_unit.sv
// Top level of the HZ (GB 2312) stream decoder.
//
// channel  dir  tdata                     tuser         tlast
// s_*      in   [7:0] in_byte             -             end_of_text
// m_*      out  [7:0] byte_high,          [1:0] kind    -
//               [15:8] byte_low
//
// One byte is taken every cycle while s_tready is high; its result reaches
// m_* through the input register and then the result register.
// The decode state updates as a byte moves from the input register on.
// Reset clears both valid flags and returns the decoder to plain mode.
// A stall on m_tready holds the result and fills the input register only.
module hz_gb2312_stream_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] byte_high, [15:8] byte_low
	output logic [1:0]  m_tuser    // [1:0] item_kind
);
	import hzd_pkg::*;

	in_item_t s_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	result_t  result;

	assign s_item = '{in_byte: s_tdata, end_of_text: s_tlast};

	hzd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hzd_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.result  (result)
	);

	hzd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> verif/hz_gb2312_stream_decoder_unit_tb.sv
// Self-checking regression bench for the HZ / GB 2312 stream decoder.
`timescale 1ns / 100ps

module hz_gb2312_stream_decoder_unit_tb;
	import hzd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_PRINTS = 40;

	typedef enum logic [2:0] {
		HZ_PLAIN    = 3'd0,
		HZ_TILDE    = 3'd1,
		HZ_GB       = 3'd2,
		HZ_GB_TILDE = 3'd3,
		HZ_GB_HALF  = 3'd4,
		HZ_GR_HALF  = 3'd5
	} hz_mode_e;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] hi;
		logic [7:0] lo;
	} hz_char_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	hz_mode_e   dec_mode = HZ_PLAIN;
	logic [7:0] prev_byte = 8'h00;
	hz_char_t   decoded_chars [$];
	hz_char_t   oldest_char;

	int  err_count = 0;
	int  cycles = 0;
	int  stall_left = 0;
	bit  steady = 1'b0;
	int  text_left = 40;
	int  texts_done = 0;
	int  sent = 0;
	bit  in_gb = 1'b0;

	hz_gb2312_stream_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("hz_gb2312_stream_decoder_unit regression: fail");
			$finish;
		end
	end

	function automatic bit is_gl(input logic [7:0] b);
		return b >= 8'h21 && b <= 8'h7E;
	endfunction

	function automatic bit is_gr(input logic [7:0] b);
		return b >= 8'hA1 && b <= 8'hFE;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		hz_mode_e   m;
		bit         hit;
		kind_t      k;
		logic [7:0] hi;
		hz_char_t   c;
		m = dec_mode;
		hit = 1'b0;
		k = KIND_ASCII;
		hi = 8'h00;
		case (dec_mode)
		HZ_TILDE: begin
			if (b == CH_ENTER) begin
				m = HZ_GB;
			end else begin
				if (b == CH_TILDE) begin
					hit = 1'b1;
					k = KIND_ASCII;
				end else if (b != CH_NEWLINE) begin
					hit = 1'b1;
					k = KIND_UNK2;
					hi = prev_byte;
				end
				m = HZ_PLAIN;
			end
		end
		HZ_GB_TILDE: begin
			if (b == CH_LEAVE || b == CH_NEWLINE) begin
				m = HZ_PLAIN;
			end else begin
				hit = 1'b1;
				k = is_gl({1'b0, b[6:0]}) ? KIND_GB : KIND_UNK2;
				hi = prev_byte;
				m = HZ_GB;
			end
		end
		HZ_GB: begin
			if (b == CH_TILDE) begin
				m = HZ_GB_TILDE;
			end else if (is_gl({1'b0, b[6:0]})) begin
				m = HZ_GB_HALF;
			end else begin
				hit = 1'b1;
				k = KIND_UNK1;
			end
		end
		HZ_GB_HALF: begin
			hit = 1'b1;
			k = is_gl({1'b0, b[6:0]}) ? KIND_GB : KIND_UNK2;
			hi = prev_byte;
			m = HZ_GB;
		end
		HZ_GR_HALF: begin
			hit = 1'b1;
			k = is_gr(b) ? KIND_GB : KIND_UNK2;
			hi = prev_byte;
			m = HZ_PLAIN;
		end
		default: begin
			m = HZ_PLAIN;
			if (b == CH_TILDE) begin
				m = HZ_TILDE;
			end else if (is_gr(b)) begin
				m = HZ_GR_HALF;
			end else begin
				hit = 1'b1;
				k = b[7] ? KIND_UNK1 : KIND_ASCII;
			end
		end
		endcase
		if (last) begin
			if (!hit && (m == HZ_TILDE || m == HZ_GB_TILDE || m == HZ_GB_HALF ||
			    m == HZ_GR_HALF)) begin
				hit = 1'b1;
				k = KIND_UNK1;
				hi = 8'h00;
			end
			dec_mode = HZ_PLAIN;
			prev_byte = 8'h00;
		end else begin
			dec_mode = m;
			prev_byte = b;
		end
		if (hit) begin
			c.kind = k;
			c.hi = hi;
			c.lo = b;
			decoded_chars.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [17:0] got,
		input logic [17:0] want);
		if (err_count < MAX_PRINTS)
			$display("mismatch %s: got %h, expected %h (cycle %0d)", what, got, want, cycles);
		err_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_chars.size() == 0) begin
					report_mismatch("unexpected item", {m_tuser, m_tdata}, 18'h0);
				end else begin
					oldest_char = decoded_chars.pop_front();
					if (m_tuser !== oldest_char.kind)
						report_mismatch("item_kind", 18'(m_tuser), 18'(oldest_char.kind));
					if (m_tdata[7:0] !== oldest_char.hi)
						report_mismatch("byte_high", 18'(m_tdata[7:0]), 18'(oldest_char.hi));
					if (m_tdata[15:8] !== oldest_char.lo)
						report_mismatch("byte_low", 18'(m_tdata[15:8]), 18'(oldest_char.lo));
				end
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!steady && $urandom_range(0, 99) < 15)
					stall_left = gap_len();
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = (!steady && $urandom_range(0, 99) < 25) ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = b;
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic release_input();
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast = 1'b0;
	endtask

	task automatic wait_drained();
		while (decoded_chars.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_text_byte(input logic [7:0] b);
		logic last;
		last = (text_left <= 1);
		send_byte(b, last);
		sent++;
		if (last) begin
			text_left = $urandom_range(1, 80);
			texts_done++;
			in_gb = 1'b0;
		end else begin
			text_left--;
		end
	endtask

	function automatic logic [7:0] gb_byte(input bit lead);
		logic [7:0] b;
		b = lead ? 8'($urandom_range(8'h21, 8'h7D)) : 8'($urandom_range(8'h21, 8'h7E));
		if ($urandom_range(0, 3) == 0)
			b[7] = 1'b1;
		return b;
	endfunction

	task automatic test_directed();
		logic [8:0] seq [25];
		seq = '{9'h000, 9'h0FF, 9'h07F,
			{1'b0, CH_TILDE}, {1'b0, CH_TILDE},
			{1'b0, CH_TILDE}, {1'b0, CH_NEWLINE},
			{1'b0, CH_TILDE}, 9'h041,
			{1'b0, CH_TILDE}, {1'b0, CH_ENTER},
			9'h0B0, 9'h0A1, 9'h020,
			{1'b0, CH_TILDE}, 9'h030,
			{1'b0, CH_TILDE}, 9'h080,
			9'h041, {1'b0, CH_NEWLINE},
			{1'b0, CH_TILDE}, {1'b0, CH_LEAVE},
			9'h0B0, 9'h041, 9'h1A1};
		steady = 1'b1;
		foreach (seq[i])
			send_byte(seq[i][7:0], seq[i][8]);
		release_input();
	endtask

	task automatic test_drain_pause();
		steady = 1'b0;
		send_byte(CH_TILDE, 1'b0);
		send_byte(CH_ENTER, 1'b0);
		repeat (4) begin
			send_byte(gb_byte(1'b1), 1'b0);
			send_byte(gb_byte(1'b0), 1'b0);
		end
		send_byte(CH_TILDE, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		release_input();
		wait_drained();
		send_byte(8'hC4, 1'b0);
		send_byte(8'hE3, 1'b0);
		send_byte(CH_TILDE, 1'b1);
		release_input();
		wait_drained();
	endtask

	task automatic test_random_texts(input int n, input bit no_gaps);
		int r;
		int mark;
		logic [7:0] a;
		steady = no_gaps;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (!in_gb) begin
				if (r < 40) begin
					a = 8'($urandom_range(0, 127));
					if (a == CH_TILDE)
						put_text_byte(CH_TILDE);
					put_text_byte(a);
				end else if (r < 48) begin
					put_text_byte(CH_TILDE);
					put_text_byte(CH_TILDE);
				end else if (r < 53) begin
					put_text_byte(CH_TILDE);
					put_text_byte(CH_NEWLINE);
				end else if (r < 68) begin
					put_text_byte(8'($urandom_range(8'hA1, 8'hFE)));
					put_text_byte(8'($urandom_range(8'hA1, 8'hFE)));
				end else if (r < 85) begin
					mark = texts_done;
					put_text_byte(CH_TILDE);
					put_text_byte(CH_ENTER);
					if (mark == texts_done)
						in_gb = 1'b1;
				end else begin
					put_text_byte(8'($urandom_range(0, 255)));
				end
			end else begin
				if (r < 60) begin
					put_text_byte(gb_byte(1'b1));
					put_text_byte(gb_byte(1'b0));
				end else if (r < 68) begin
					put_text_byte(CH_TILDE);
					a = gb_byte(1'b0);
					put_text_byte(a == CH_LEAVE ? CH_ENTER : a);
				end else if (r < 78) begin
					put_text_byte(CH_TILDE);
					put_text_byte(CH_LEAVE);
					in_gb = 1'b0;
				end else if (r < 84) begin
					put_text_byte(CH_TILDE);
					put_text_byte(CH_NEWLINE);
					in_gb = 1'b0;
				end else begin
					put_text_byte(8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_drain_pause();
		test_random_texts(800, 1'b0);
		test_random_texts(200, 1'b1);
		test_random_texts(600, 1'b0);
		release_input();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (decoded_chars.size() != 0)
			report_mismatch("items never seen", 18'(decoded_chars.size()), 18'h0);

		if (err_count == 0)
			$display("hz_gb2312_stream_decoder_unit regression: pass");
		else
			$display("hz_gb2312_stream_decoder_unit regression: fail");
		$finish;
	end

endmodule
